// File: hw/rtl/deq_pkg.sv
`timescale 1ns / 1ps

package deq_pkg;

  localparam logic [2:0] CMD_PUSH_FRONT = 3'd0;
  localparam logic [2:0] CMD_PUSH_BACK  = 3'd1;
  localparam logic [2:0] CMD_POP_FRONT  = 3'd2;
  localparam logic [2:0] CMD_POP_BACK   = 3'd3;
  localparam logic [2:0] CMD_NONE       = 3'd4;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2
  } status_t;

  typedef enum logic {
    S_IDLE,
    S_FILL
  } state_t;

endpackage

// File: hw/rtl/double_ended_queue_core.sv
`timescale 1ns / 1ps

// Bounded double-ended queue of DEPTH words held in a ring in one synchronous
// RAM. Each request carries a command (push front, push back, pop front, pop
// back, none; codes 5 to 7 act as none) and returns one response with the
// popped word, a status (ok, empty on pop, full on push), the count after the
// request and the words now at the front and back (zero when empty). The
// front and back words are cached in registers, so only a pop that leaves
// the queue non-empty needs a RAM read: it passes through a refill state
// that loads the read word into the cached end before the response is formed.
// The response is registered and appears the cycle after it is final; a new
// request is taken only when no response waits or the waiting one leaves in
// the same cycle.
module double_ended_queue_core
  import deq_pkg::*;
#(
  parameter int DEPTH      = 16,
  parameter int DATA_WIDTH = 32
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [2:0]                    in_cmd,
  input  logic [DATA_WIDTH-1:0]         in_push_value,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [DATA_WIDTH-1:0]         out_popped_value,
  output logic [1:0]                    out_status,
  output logic [$clog2(DEPTH+1)-1:0]    out_entry_count_out,
  output logic [DATA_WIDTH-1:0]         out_front_value,
  output logic [DATA_WIDTH-1:0]         out_back_value
);

  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [AW-1:0] LAST_IDX = AW'(DEPTH - 1);
  localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

  state_t state_r, state_nxt;
  logic [AW-1:0] front_idx_r, front_idx_nxt;
  logic [AW-1:0] back_idx_r, back_idx_nxt;
  logic [CW-1:0] count_r, count_nxt;
  logic [DATA_WIDTH-1:0] front_val_r, front_val_nxt;
  logic [DATA_WIDTH-1:0] back_val_r, back_val_nxt;
  logic [DATA_WIDTH-1:0] pop_hold_r, pop_hold_nxt;
  logic fill_front_r, fill_front_nxt;

  logic out_valid_r, out_valid_nxt;
  logic [DATA_WIDTH-1:0] out_popped_r, out_popped_nxt;
  status_t out_status_r, out_status_nxt;
  logic [CW-1:0] out_count_r, out_count_nxt;
  logic [DATA_WIDTH-1:0] out_front_r, out_front_nxt;
  logic [DATA_WIDTH-1:0] out_back_r, out_back_nxt;

  logic [DATA_WIDTH-1:0] mem_r [DEPTH];
  logic [DATA_WIDTH-1:0] rd_data_r;
  logic mem_we, mem_re;
  logic [AW-1:0] mem_waddr, mem_raddr;

  logic load_out;
  logic [DATA_WIDTH-1:0] popped;
  status_t status;
  logic [AW-1:0] front_inc, front_dec, back_inc, back_dec;

  assign front_inc = (front_idx_r == LAST_IDX) ? '0 : front_idx_r + 1'b1;
  assign front_dec = (front_idx_r == '0) ? LAST_IDX : front_idx_r - 1'b1;
  assign back_inc  = (back_idx_r == LAST_IDX) ? '0 : back_idx_r + 1'b1;
  assign back_dec  = (back_idx_r == '0) ? LAST_IDX : back_idx_r - 1'b1;

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem_r[mem_waddr] <= in_push_value;
    end
    if (mem_re) begin
      rd_data_r <= mem_r[mem_raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      front_idx_r <= '0;
      back_idx_r  <= LAST_IDX;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      front_idx_r <= front_idx_nxt;
      back_idx_r  <= back_idx_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    front_val_r  <= front_val_nxt;
    back_val_r   <= back_val_nxt;
    pop_hold_r   <= pop_hold_nxt;
    fill_front_r <= fill_front_nxt;
    out_popped_r <= out_popped_nxt;
    out_status_r <= out_status_nxt;
    out_count_r  <= out_count_nxt;
    out_front_r  <= out_front_nxt;
    out_back_r   <= out_back_nxt;
  end

  always_comb begin
    state_nxt      = state_r;
    front_idx_nxt  = front_idx_r;
    back_idx_nxt   = back_idx_r;
    count_nxt      = count_r;
    front_val_nxt  = front_val_r;
    back_val_nxt   = back_val_r;
    pop_hold_nxt   = pop_hold_r;
    fill_front_nxt = fill_front_r;
    out_valid_nxt  = out_valid_r && !out_ready;
    out_popped_nxt = out_popped_r;
    out_status_nxt = out_status_r;
    out_count_nxt  = out_count_r;
    out_front_nxt  = out_front_r;
    out_back_nxt   = out_back_r;
    mem_we         = 1'b0;
    mem_re         = 1'b0;
    mem_waddr      = front_dec;
    mem_raddr      = front_inc;
    load_out       = 1'b0;
    popped         = '0;
    status         = ST_OK;
    in_ready       = 1'b0;

    case (state_r)
      S_IDLE: begin
        in_ready = !out_valid_r || out_ready;
        if (in_valid && in_ready) begin
          load_out = 1'b1;
          case (in_cmd)
            CMD_PUSH_FRONT: begin
              if (count_r == FULL_CNT) begin
                status = ST_FULL;
              end else begin
                mem_we        = 1'b1;
                mem_waddr     = front_dec;
                front_idx_nxt = front_dec;
                count_nxt     = count_r + 1'b1;
                front_val_nxt = in_push_value;
                if (count_r == '0) begin
                  back_val_nxt = in_push_value;
                end
              end
            end
            CMD_PUSH_BACK: begin
              if (count_r == FULL_CNT) begin
                status = ST_FULL;
              end else begin
                mem_we       = 1'b1;
                mem_waddr    = back_inc;
                back_idx_nxt = back_inc;
                count_nxt    = count_r + 1'b1;
                back_val_nxt = in_push_value;
                if (count_r == '0) begin
                  front_val_nxt = in_push_value;
                end
              end
            end
            CMD_POP_FRONT: begin
              if (count_r == '0) begin
                status = ST_EMPTY;
              end else begin
                popped        = front_val_r;
                front_idx_nxt = front_inc;
                count_nxt     = count_r - 1'b1;
                if (count_r != CW'(1)) begin
                  mem_re         = 1'b1;
                  mem_raddr      = front_inc;
                  fill_front_nxt = 1'b1;
                  pop_hold_nxt   = front_val_r;
                  load_out       = 1'b0;
                  state_nxt      = S_FILL;
                end
              end
            end
            CMD_POP_BACK: begin
              if (count_r == '0) begin
                status = ST_EMPTY;
              end else begin
                popped       = back_val_r;
                back_idx_nxt = back_dec;
                count_nxt    = count_r - 1'b1;
                if (count_r != CW'(1)) begin
                  mem_re         = 1'b1;
                  mem_raddr      = back_dec;
                  fill_front_nxt = 1'b0;
                  pop_hold_nxt   = back_val_r;
                  load_out       = 1'b0;
                  state_nxt      = S_FILL;
                end
              end
            end
            default: ;
          endcase
        end
      end
      S_FILL: begin
        if (fill_front_r) begin
          front_val_nxt = rd_data_r;
        end else begin
          back_val_nxt = rd_data_r;
        end
        popped    = pop_hold_r;
        load_out  = 1'b1;
        state_nxt = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase

    if (load_out) begin
      out_valid_nxt  = 1'b1;
      out_popped_nxt = popped;
      out_status_nxt = status;
      out_count_nxt  = count_nxt;
      out_front_nxt  = (count_nxt == '0) ? '0 : front_val_nxt;
      out_back_nxt   = (count_nxt == '0) ? '0 : back_val_nxt;
    end
  end

  assign out_valid           = out_valid_r;
  assign out_popped_value    = out_popped_r;
  assign out_status          = out_status_r;
  assign out_entry_count_out = out_count_r;
  assign out_front_value     = out_front_r;
  assign out_back_value      = out_back_r;

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= FULL_CNT)
    else $error("entry count above depth");

  a_fill_slot_free: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_FILL |-> !out_valid_r && !in_ready)
    else $error("refill with output slot busy or input open");

  a_full_count: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_status_r == ST_FULL |-> out_count_r == FULL_CNT)
    else $error("full status with count below depth");

  a_pop_dec: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && count_r != '0
      && (in_cmd == CMD_POP_FRONT || in_cmd == CMD_POP_BACK)
      |=> count_r == $past(count_r) - 1'b1)
    else $error("pop did not decrement count");

endmodule
